>>> rtl/core/sha256_pkg.sv
// ============================================================================
// SHA-256 shared definitions
// Word and hash-state types, the initial hash value, the round constants and
// the sigma functions used by the round unit.
// ============================================================================
package sha256_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [7:0][31:0] hash_type;   // [0] is a / H0, [7] is h / H7
   typedef logic [511:0]     block_type;  // sixteen words, word 0 in the top bits

   localparam hash_type HASH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

>>> rtl/core/sha256_stream_hasher.sv
// ============================================================================
// SHA-256 stream hasher
// Byte-serial SHA-256 with a sequencer around one shared round unit.
// ============================================================================
// Usage:
//   req channel: one word per handshake (req_msg_byte with req_byte_valid,
//   req_end_of_message). A word with req_byte_valid low and end low is a
//   no-op; an end word with no byte closes the message as it stands.
//   rsp channel: eight digest words, index 0 first, rsp_last_word on index 7.
//   Flow: req_ready is high only while the sequencer is idle. A byte that
//   fills the block starts a compression: a load, 64 rounds through the
//   single round unit, then a fold back into the hash state.
//   An end word pads the block byte by byte (0x80, zeros, 8 length bytes),
//   with one or two compressions, then presents the eight digest words,
//   one per cycle while rsp_ready is high.
//   A stalled receiver just holds the current digest word; nothing is lost.
//   After the last digest word is taken the hash state returns to the initial
//   value and the block is ready for the next message.
//   Reset (synchronous, active high) loads the initial hash value and clears
//   the fill count and bit length.
// ============================================================================
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD80 = 3'd1;
   localparam logic [2:0] S_PADZ  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_ROUND = 3'd5;
   localparam logic [2:0] S_FOLD  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   localparam logic [1:0] RET_IDLE  = 2'd0;
   localparam logic [1:0] RET_PAD80 = 2'd1;
   localparam logic [1:0] RET_PADZ  = 2'd2;
   localparam logic [1:0] RET_OUT   = 2'd3;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_LEN  = 6'd56;
   localparam logic [7:0] PAD_BYTE  = 8'h80;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [2:0]  idx_ff, idx_in;
   logic [5:0]  rnd_ff, rnd_in;
   hash_type    hash_ff, hash_in;
   hash_type    work_ff, work_in;
   block_type   block_ff, block_in;

   hash_type    work_nxt;
   block_type   sched_nxt;
   logic        push_en;
   logic [7:0]  push_byte;

   sha256_round u_round (
      .work_i  (work_ff),
      .sched_i (block_ff),
      .round_i (rnd_ff),
      .work_o  (work_nxt),
      .sched_o (sched_nxt)
   );

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      idx_in    = idx_ff;
      rnd_in    = rnd_ff;
      hash_in   = hash_ff;
      work_in   = work_ff;
      block_in  = block_ff;
      push_en   = 1'b0;
      push_byte = 8'h00;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               push_en   = req_byte_valid;
               push_byte = req_msg_byte;
               if (req_byte_valid) begin
                  bits_in = bits_ff + 64'd8;
               end
               if (req_byte_valid && fill_ff == FILL_LAST) begin
                  state_in = S_LOAD;
                  ret_in   = req_end_of_message ? RET_PAD80 : RET_IDLE;
               end else if (req_end_of_message) begin
                  state_in = S_PAD80;
               end
            end
         end
         S_PAD80: begin
            push_en   = 1'b1;
            push_byte = PAD_BYTE;
            state_in  = (fill_ff == FILL_LAST) ? S_LOAD : S_PADZ;
            ret_in    = RET_PADZ;
         end
         S_PADZ: begin
            if (fill_ff == FILL_LEN) begin
               state_in = S_LEN;
            end else begin
               push_en = 1'b1;
               if (fill_ff == FILL_LAST) begin
                  state_in = S_LOAD;
                  ret_in   = RET_PADZ;
               end
            end
         end
         S_LEN: begin
            // bit length goes out big-endian; the counter is cleared at the end anyway
            push_en   = 1'b1;
            push_byte = bits_ff[63:56];
            bits_in   = {bits_ff[55:0], 8'h00};
            if (fill_ff == FILL_LAST) begin
               state_in = S_LOAD;
               ret_in   = RET_OUT;
            end
         end
         S_LOAD: begin
            work_in  = hash_ff;
            rnd_in   = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            work_in  = work_nxt;
            block_in = sched_nxt;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == FILL_LAST) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            idx_in = '0;
            unique case (ret_ff)
               RET_IDLE:  state_in = S_IDLE;
               RET_PAD80: state_in = S_PAD80;
               RET_PADZ:  state_in = S_PADZ;
               RET_OUT:   state_in = S_OUT;
               default:   state_in = S_IDLE;
            endcase
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               for (int i = 0; i < 7; i++) begin
                  hash_in[i] = hash_ff[i + 1];
               end
               hash_in[7] = hash_ff[0];
               if (idx_ff == 3'd7) begin
                  hash_in  = HASH_IV;
                  bits_in  = '0;
                  fill_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (push_en) begin
         block_in = {block_ff[503:0], push_byte};
         fill_in  = fill_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         idx_ff   <= '0;
         hash_ff  <= HASH_IV;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         idx_ff   <= idx_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff   <= rnd_in;
      work_ff  <= work_in;
      block_ff <= block_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = hash_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

endmodule

>>> rtl/core/sha256_round.sv
// ============================================================================
// SHA-256 round unit
// One compression round plus one step of the sliding message schedule.
// Reused for all 64 rounds of every block under the top-level sequencer.
// ============================================================================
module sha256_round
   import sha256_pkg::*;
(
   input  hash_type   work_i,
   input  block_type  sched_i,
   input  logic [5:0] round_i,
   output hash_type   work_o,
   output block_type  sched_o
);

   word_type w0, w1, w9, w14, w_next;
   word_type ch, maj, t1, t2;

   assign w0  = sched_i[511:480];
   assign w1  = sched_i[479:448];
   assign w9  = sched_i[223:192];
   assign w14 = sched_i[63:32];

   // word t+16 of the schedule, window slides one word per round
   assign w_next  = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
   assign sched_o = {sched_i[479:0], w_next};

   assign ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
   assign maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
   assign t1  = work_i[7] + big_sigma1(work_i[4]) + ch + ROUND_K[round_i] + w0;
   assign t2  = big_sigma0(work_i[0]) + maj;

   always_comb begin
      work_o[0] = t1 + t2;
      work_o[1] = work_i[0];
      work_o[2] = work_i[1];
      work_o[3] = work_i[2];
      work_o[4] = work_i[3] + t1;
      work_o[5] = work_i[4];
      work_o[6] = work_i[5];
      work_o[7] = work_i[6];
   end

endmodule

>>> dv/sha256_stream_hasher_test.sv
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 stream hasher testbench
// Sends byte streams with random framing, random sender gaps and receiver
// stalls. A scoreboard class hashes each accepted word in software and checks
// every digest word, field by field, in order.
// ============================================================================

typedef struct packed {
   logic [31:0] word;
   logic [2:0]  index;
   logic        last;
} digest_entry_type;

class digest_scoreboard;
   bit [31:0]        round_k [64];
   bit [31:0]        iv [8];
   bit [31:0]        hash_state [8];
   bit [7:0]         block_bytes [64];
   bit [6:0]         fill;
   bit [63:0]        message_bits;
   digest_entry_type digest_queue [$];
   int               failures;

   function new();
      round_k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      failures = 0;
      restart();
   endfunction

   function void restart();
      hash_state = iv;
      fill = '0;
      message_bits = '0;
   endfunction

   function bit [31:0] ror32(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function void compress_block();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      v = hash_state;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++)
         hash_state[j] += v[j];
   endfunction

   // one accepted request word
   function void absorb_word(bit [7:0] msg_byte, bit byte_valid, bit end_of_message);
      bit [63:0]        total;
      int               j;
      digest_entry_type entry;
      if (byte_valid) begin
         block_bytes[fill[5:0]] = msg_byte;
         fill++;
         if (fill == 7'd64) begin
            compress_block();
            message_bits += 64'd512;
            fill = '0;
         end
      end
      if (!end_of_message)
         return;
      total = message_bits + {54'd0, fill, 3'b000};
      j = fill;
      block_bytes[j] = 8'h80;
      j++;
      // no room for the length: pad out and compress an extra block
      if (fill >= 7'd56) begin
         while (j < 64) begin
            block_bytes[j] = 8'h00;
            j++;
         end
         compress_block();
         j = 0;
      end
      while (j < 56) begin
         block_bytes[j] = 8'h00;
         j++;
      end
      for (int k = 0; k < 8; k++)
         block_bytes[63-k] = total[8*k +: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
         entry.word  = hash_state[k];
         entry.index = k[2:0];
         entry.last  = (k == 7);
         digest_queue.push_back(entry);
      end
      restart();
   endfunction

   function void check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_entry_type exp_entry;
      if (digest_queue.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected digest word %h index %0d last %b", word, index, last);
         return;
      end
      exp_entry = digest_queue.pop_front();
      if (word !== exp_entry.word || index !== exp_entry.index || last !== exp_entry.last) begin
         failures++;
         if (failures <= 10)
            $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     exp_entry.word, exp_entry.index, exp_entry.last, word, index, last);
      end
   endfunction

   function int pending();
      return digest_queue.size();
   endfunction
endclass

module sha256_stream_hasher_test;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_msg_byte;
   logic        req_byte_valid;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard board;
   int               item_count;
   bit               no_idle;

   sha256_stream_hasher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_msg_byte       (req_msg_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset)
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 33);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_digest_word(rsp_digest_word, rsp_word_index, rsp_last_word);
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input logic [7:0] msg_byte, input logic byte_valid,
                            input logic end_of_message);
      no_idle = (item_count >= 60 && item_count < 110);
      while (!no_idle && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_msg_byte       <= msg_byte;
      req_byte_valid     <= byte_valid;
      req_end_of_message <= end_of_message;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.absorb_word(msg_byte, byte_valid, end_of_message);
      if (byte_valid || end_of_message)
         item_count++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len, input bit bare_end);
      for (int i = 0; i < len; i++) begin
         // stray no-op words mixed into the stream
         if ($urandom_range(0, 99) < 8)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !bare_end);
      end
      if (bare_end || len == 0)
         send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int sel;
      int len;
      board              = new();
      item_count         = 0;
      no_idle            = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_msg_byte       = 8'h00;
      req_byte_valid     = 1'b0;
      req_end_of_message = 1'b0;
      rsp_ready          = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(8'h00, 1'b0, 1'b1);     // empty message
      send_word(8'hff, 1'b0, 1'b0);     // no-op
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);     // "abc"
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      send_word(8'h5a, 1'b1, 1'b0);     // byte, no-op, then bare end marker
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hff, 1'b0, 1'b1);

      while (item_count < 150) begin
         sel = $urandom_range(0, 99);
         if (sel < 62)
            len = $urandom_range(0, 12);
         else if (sel < 94)
            len = $urandom_range(54, 66);   // around the pad and block boundaries
         else
            len = $urandom_range(118, 130);
         send_message(len, 1'($urandom_range(0, 1)));
      end
      req_valid <= 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.failures == 0)
         $display("sha256_stream_hasher_test passed");
      else
         $display("sha256_stream_hasher_test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("sha256_stream_hasher_test failed");
      $finish;
   end
endmodule
